FILE: hdl/dtrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty tile rectangle merger - shared definitions
// Map geometry, request codes, register addresses, sequencer states and a
// one-hot to index encoder.
// ----------------------------------------------------------------------------
package dtrm_pkg;

   localparam int TILE_SHIFT = 5;                 // 32 pixel tiles
   localparam int MAP_COLS   = 64;
   localparam int MAP_ROWS   = 64;
   localparam int COL_AW     = 6;
   localparam int ROW_AW     = 6;
   localparam logic [11:0] SURF_MAX = 12'd2048;  // MAP_COLS * tile width

   // Request codes
   localparam logic [1:0] REQ_MARK  = 2'd0;
   localparam logic [1:0] REQ_FETCH = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_SPARE = 2'd3;      // unused, leaves the map alone

   // Register index (address bit 2)
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_CLIP = 11'b000_0000_0010,
      ST_MAP  = 11'b000_0000_0100,
      ST_MRD  = 11'b000_0000_1000,
      ST_MWR  = 11'b000_0001_0000,
      ST_FRD  = 11'b000_0010_0000,
      ST_FCHK = 11'b000_0100_0000,
      ST_GRD  = 11'b000_1000_0000,
      ST_GCHK = 11'b001_0000_0000,
      ST_FIN  = 11'b010_0000_0000,
      ST_OUT  = 11'b100_0000_0000
   } state_type;

   // Encode a one-hot column word to its bit position
   function automatic logic [COL_AW-1:0] onehot_index(input logic [MAP_COLS-1:0] v);
      logic [COL_AW-1:0] idx;
      idx = '0;
      for (int i = 0; i < MAP_COLS; i++) begin
         if (v[i]) idx = idx | COL_AW'(i);
      end
      return idx;
   endfunction

endpackage

FILE: hdl/dtrm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtrm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: hdl/dirty_tile_rect_merger_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty tile rectangle merger
// Tracks a 64 x 64 dirty map of 32 x 32 pixel tiles, marks damage rectangles
// and hands back merged dirty rectangles in raster order.
// ----------------------------------------------------------------------------
//  port group | direction | contents
//  req_*      | in        | tuser: req_type; tdata: rect_x, rect_y, rect_w, rect_h
//  rsp_*      | out       | tuser: found; tdata: out_x, out_y, out_w, out_h
//  csr_*      | APB       | 0x0 surface_width, 0x4 surface_height
//
// One row of the map (64 tiles) is held per RAM word; the single RAM port
// pair sets the pace. A mark reads and then rewrites each row that it touches; a fetch
// reads rows while it scans and then while it checks them for merging. A clear request,
// reset and register writes clear the map at once through per-row valid bits.
// A finished result holds in the output register while rsp_tready is low;
// no request is taken until it has gone.
// ----------------------------------------------------------------------------
module dirty_tile_rect_merger_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // rect_x[12:0], rect_y[25:13], rect_w[38:26],
                                    // rect_h[51:39], zero pad
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_x[10:0], out_y[21:11], out_w[33:22],
                                    // out_h[45:34], zero pad
   output logic [0:0]  rsp_tuser,   // found[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = dtrm_pkg::COL_AW;
   localparam int RW = dtrm_pkg::ROW_AW;
   localparam int NC = dtrm_pkg::MAP_COLS;
   localparam int NR = dtrm_pkg::MAP_ROWS;

   dtrm_pkg::state_type state_ff, state_in;

   logic [11:0] surf_w_ff, surf_h_ff;
   logic [NR-1:0] row_valid_ff, row_valid_in;
   logic        rdv_ff;
   logic [RW-1:0] row_ff, row_in;
   logic [1:0]  type_ff, type_in;
   logic signed [14:0] x_ff, y_ff, w_ff, h_ff, x_in, y_in, w_in, h_in;
   logic        drop_ff, drop_in;
   logic [RW-1:0] tyy_ff, tyy_in;
   logic [NC-1:0] mask_ff, mask_in;
   logic [CW-1:0] tx_ff, tx_in;
   logic [RW-1:0] ty_ff, ty_in;
   logic [6:0]  xx_ff, xx_in, yy_ff, yy_in;
   logic        found_ff, found_in;
   logic [10:0] ox_ff, oy_ff, ox_in, oy_in;
   logic [11:0] ow_ff, oh_ff, ow_in, oh_in;

   logic          ram_we;
   logic [NC-1:0] ram_wdata, ram_rdata, row_data;

   logic [11:0] sw, sh;
   logic [6:0]  ntx, nty;
   logic        csr_wr;
   logic        last_row;

   // Effective surface, clamped to the map
   assign sw  = (surf_w_ff > dtrm_pkg::SURF_MAX) ? dtrm_pkg::SURF_MAX : surf_w_ff;
   assign sh  = (surf_h_ff > dtrm_pkg::SURF_MAX) ? dtrm_pkg::SURF_MAX : surf_h_ff;
   assign ntx = 7'((13'(sw) + 13'd31) >> dtrm_pkg::TILE_SHIFT);
   assign nty = 7'((13'(sh) + 13'd31) >> dtrm_pkg::TILE_SHIFT);

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == dtrm_pkg::CSR_HEIGHT) ? {20'd0, surf_h_ff}
                                                              : {20'd0, surf_w_ff};

   assign req_tready = (state_ff == dtrm_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == dtrm_pkg::ST_OUT);
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = {2'd0, oh_ff, ow_ff, oy_ff, ox_ff};

   // Rows never written since the last clear read as clean
   assign row_data = rdv_ff ? ram_rdata : '0;
   assign last_row = ({1'b0, row_ff} + 7'd1) >= nty;

   dtrm_ram #(.WIDTH(NC), .DEPTH(NR)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (row_ff),
      .wdata (ram_wdata),
      .raddr (row_ff),
      .rdata (ram_rdata)
   );

   // Sequencer
   always_comb begin
      logic signed [14:0] sw15, sh15, x1, y1, w1, h1, w2, xe, ye;
      logic [NC-1:0]      low, sum, run;
      logic [NC:0]        top;
      logic [CW:0]        e;
      logic [12:0]        rx, ry, rw, rh;
      sw15 = 15'(sw);
      sh15 = 15'(sh);
      x1 = '0; y1 = '0; w1 = '0; h1 = '0; w2 = '0; xe = '0; ye = '0;
      low = '0; sum = '0; run = '0; top = '0; e = '0;
      rx = '0; ry = '0; rw = '0; rh = '0;

      state_in     = state_ff;
      row_valid_in = row_valid_ff;
      row_in  = row_ff;   type_in = type_ff;
      x_in = x_ff; y_in = y_ff; w_in = w_ff; h_in = h_ff;
      drop_in = drop_ff;  tyy_in = tyy_ff; mask_in = mask_ff;
      tx_in = tx_ff; ty_in = ty_ff; xx_in = xx_ff; yy_in = yy_ff;
      found_in = found_ff;
      ox_in = ox_ff; oy_in = oy_ff; ow_in = ow_ff; oh_in = oh_ff;
      ram_we    = 1'b0;
      ram_wdata = '0;

      unique case (state_ff)
         dtrm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               type_in  = req_tuser;
               x_in     = 15'(signed'(req_tdata[12:0]));
               y_in     = 15'(signed'(req_tdata[25:13]));
               w_in     = 15'(signed'(req_tdata[38:26]));
               h_in     = 15'(signed'(req_tdata[51:39]));
               found_in = 1'b0;
               row_in   = '0;
               case (req_tuser)
                  dtrm_pkg::REQ_MARK:  state_in = dtrm_pkg::ST_CLIP;
                  dtrm_pkg::REQ_FETCH: state_in = (nty == 7'd0) ? dtrm_pkg::ST_FIN
                                                                : dtrm_pkg::ST_FRD;
                  dtrm_pkg::REQ_CLEAR: begin
                     row_valid_in = '0;
                     state_in     = dtrm_pkg::ST_FIN;
                  end
                  default: state_in = dtrm_pkg::ST_FIN;
               endcase
            end
         end
         // Clip to the surface
         dtrm_pkg::ST_CLIP: begin
            drop_in = (w_ff <= 0) || (h_ff <= 0) || (sw == 12'd0) || (sh == 12'd0);
            x1 = (x_ff < 0) ? 15'sd0 : x_ff;
            w1 = (x_ff < 0) ? w_ff + x_ff : w_ff;
            y1 = (y_ff < 0) ? 15'sd0 : y_ff;
            h1 = (y_ff < 0) ? h_ff + y_ff : h_ff;
            x_in = x1;  y_in = y1;
            w_in = (x1 + w1 > sw15) ? sw15 - x1 : w1;
            h_in = (y1 + h1 > sh15) ? sh15 - y1 : h1;
            state_in = dtrm_pkg::ST_MAP;
         end
         // Widen and convert to tiles
         dtrm_pkg::ST_MAP: begin
            if (drop_ff || (w_ff <= 0) || (h_ff <= 0)) begin
               state_in = dtrm_pkg::ST_FIN;
            end else begin
               x1 = x_ff;  w2 = w_ff;
               if (w_ff > (sw15 >>> 1)) begin
                  x1 = '0;  w2 = sw15;
               end
               xe = x1 + w2 - 15'sd1;
               ye = y_ff + h_ff - 15'sd1;
               mask_in = ({NC{1'b1}} << x1[10:5]) & ({NC{1'b1}} >> (6'd63 - xe[10:5]));
               row_in   = y_ff[10:5];
               tyy_in   = ye[10:5];
               state_in = dtrm_pkg::ST_MRD;
            end
         end
         dtrm_pkg::ST_MRD: state_in = dtrm_pkg::ST_MWR;
         // Set the touched tiles of one row
         dtrm_pkg::ST_MWR: begin
            ram_we    = 1'b1;
            ram_wdata = row_data | mask_ff;
            row_valid_in[row_ff] = 1'b1;
            if (row_ff == tyy_ff) begin
               state_in = dtrm_pkg::ST_FIN;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = dtrm_pkg::ST_MRD;
            end
         end
         dtrm_pkg::ST_FRD: state_in = dtrm_pkg::ST_FCHK;
         // Scan for the first dirty row and take its leading run
         dtrm_pkg::ST_FCHK: begin
            if (row_data != '0) begin
               low = row_data & (~row_data + 1'b1);
               sum = row_data + low;
               run = row_data & ~sum;
               top = ({1'b0, row_data} + {1'b0, low}) & ~{1'b0, row_data};
               e   = top[NC] ? 7'd64 : {1'b0, dtrm_pkg::onehot_index(top[NC-1:0])};
               tx_in    = dtrm_pkg::onehot_index(low);
               xx_in    = e - {1'b0, dtrm_pkg::onehot_index(low)};
               mask_in  = run;
               ty_in    = row_ff;
               yy_in    = 7'd1;
               found_in = 1'b1;
               ram_we    = 1'b1;
               ram_wdata = row_data & ~run;
               row_valid_in[row_ff] = 1'b1;
               if (last_row) begin
                  state_in = dtrm_pkg::ST_FIN;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = dtrm_pkg::ST_GRD;
               end
            end else if (last_row) begin
               state_in = dtrm_pkg::ST_FIN;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = dtrm_pkg::ST_FRD;
            end
         end
         dtrm_pkg::ST_GRD: state_in = dtrm_pkg::ST_GCHK;
         // Grow down while the whole span stays dirty
         dtrm_pkg::ST_GCHK: begin
            if ((row_data & mask_ff) == mask_ff) begin
               ram_we    = 1'b1;
               ram_wdata = row_data & ~mask_ff;
               row_valid_in[row_ff] = 1'b1;
               yy_in = yy_ff + 7'd1;
               if (last_row) begin
                  state_in = dtrm_pkg::ST_FIN;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = dtrm_pkg::ST_GRD;
               end
            end else begin
               state_in = dtrm_pkg::ST_FIN;
            end
         end
         // Build the pixel rectangle
         dtrm_pkg::ST_FIN: begin
            rx = {2'd0, tx_ff, 5'd0};
            ry = {2'd0, ty_ff, 5'd0};
            rw = {1'b0, xx_ff, 5'd0};
            rh = {1'b0, yy_ff, 5'd0};
            if (rx + rw > 13'(sw)) rw = 13'(sw) - rx;
            if (ry + rh > 13'(sh)) rh = 13'(sh) - ry;
            found_in = found_ff && (rx < 13'(sw)) && (ry < 13'(sh)) &&
                       (type_ff == dtrm_pkg::REQ_FETCH);
            ox_in = found_in ? rx[10:0] : '0;
            oy_in = found_in ? ry[10:0] : '0;
            ow_in = found_in ? rw[11:0] : '0;
            oh_in = found_in ? rh[11:0] : '0;
            state_in = dtrm_pkg::ST_OUT;
         end
         dtrm_pkg::ST_OUT: begin
            if (rsp_tready) state_in = dtrm_pkg::ST_IDLE;
         end
         default: state_in = dtrm_pkg::ST_IDLE;
      endcase

      // A size write empties the map
      if (csr_wr) row_valid_in = '0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtrm_pkg::ST_IDLE;
         row_valid_ff <= '0;
         surf_w_ff    <= '0;
         surf_h_ff    <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         found_ff     <= found_in;
         if (csr_wr && csr_paddr[2] == dtrm_pkg::CSR_WIDTH)  surf_w_ff <= csr_pwdata[11:0];
         if (csr_wr && csr_paddr[2] == dtrm_pkg::CSR_HEIGHT) surf_h_ff <= csr_pwdata[11:0];
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      rdv_ff  <= row_valid_ff[row_ff];
      row_ff  <= row_in;   type_ff <= type_in;
      x_ff <= x_in; y_ff <= y_in; w_ff <= w_in; h_ff <= h_in;
      drop_ff <= drop_in;  tyy_ff <= tyy_in; mask_ff <= mask_in;
      tx_ff <= tx_in; ty_ff <= ty_in; xx_ff <= xx_in; yy_ff <= yy_in;
      ox_ff <= ox_in; oy_ff <= oy_in; ow_ff <= ow_in; oh_ff <= oh_in;
   end

   // Checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request taken while result pending");

   a_found_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (ow_ff != 12'd0 && oh_ff != 12'd0))
      else $error("found rectangle is empty");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("empty result carries data");

   a_csr_clear: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> (row_valid_ff == '0)) else $error("map not cleared by size write");

endmodule
